@@ rtl/rpi_pkg.sv @@
package rpi_pkg;

	// fixed-point format of all coordinates
	localparam int FRAC_BITS = 16;

	// widths of the dot products
	localparam int PW  = 64 - FRAC_BITS;  // 32x32 product after the shift
	localparam int AW  = PW + 2;          // sum of three such terms
	localparam int BPW = 65 - FRAC_BITS;  // 32x33 product after the shift
	localparam int BW  = BPW + 2;         // sum of three such terms
	localparam int RW  = AW + 1;          // divider partial remainder
	localparam int QW  = 32;              // quotient bits
	localparam int CW  = BW + AW;         // overflow compare width
	localparam int DIV_STAGES = QW;

	// configuration register indexes
	localparam logic [2:0] CFG_NORMAL_X  = 3'd0;
	localparam logic [2:0] CFG_NORMAL_Y  = 3'd1;
	localparam logic [2:0] CFG_NORMAL_Z  = 3'd2;
	localparam logic [2:0] CFG_POINT_X   = 3'd3;
	localparam logic [2:0] CFG_POINT_Y   = 3'd4;
	localparam logic [2:0] CFG_POINT_Z   = 3'd5;
	localparam logic [2:0] CFG_MATERIAL  = 3'd6;

	typedef struct packed {
		logic                 hit;
		logic                 neg;
		logic                 ovf;
		logic [AW-1:0]        mag;
		logic [RW-1:0]        rem;
		logic [QW-1:0]        num_lo;
		logic [QW-1:0]        quo;
		logic signed [31:0]   ox;
		logic signed [31:0]   oy;
		logic signed [31:0]   oz;
		logic signed [31:0]   dx;
		logic signed [31:0]   dy;
		logic signed [31:0]   dz;
	} div_stage_t;

	// one restoring step: bring down a numerator bit, trial subtract
	function automatic div_stage_t div_step(input div_stage_t d);
		div_stage_t    n;
		logic [RW-1:0] t;
		n = d;
		t = {d.rem[RW-2:0], d.num_lo[QW-1]};
		n.num_lo = {d.num_lo[QW-2:0], 1'b0};
		if (t >= RW'(d.mag)) begin
			n.rem = t - RW'(d.mag);
			n.quo = {d.quo[QW-2:0], 1'b1};
		end else begin
			n.rem = t;
			n.quo = {d.quo[QW-2:0], 1'b0};
		end
		return n;
	endfunction

endpackage

@@ rtl/ray_plane_intersect.sv @@
// ray / plane intersection, signed fixed point with FRAC_BITS fraction bits
//
// usage
// - configuration: wr_en, wr_index, wr_data write the plane normal (0..2),
//   a point on the plane (3..5) and the material id (6); other indexes are
//   ignored; write only while no ray is in flight
// - input: a ray transfer happens on a clock edge with start high and busy low;
//   busy is always low, so a new ray may enter on every cycle
// - output: result_valid is high for one cycle per ray and marks hit,
//   hit_distance, hit_x/y/z and hit_material; the receiver cannot stall
// - pipeline: a ray passes stages 1 to 3, the divider input register, the
//   32-stage restoring divider (one quotient bit per stage) that forms the
//   distance, the distance stage, the product stage and the output register
//   that raises result_valid; throughput one ray per cycle
// - reset: arst_n clears the configuration registers to zero and empties
//   the pipeline; no result appears until a ray is taken
// - a ray facing away or parallel to the plane reports a miss with all
//   fields zero; distance and point saturate to 32 bits
module ray_plane_intersect import rpi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [31:0]        wr_data,
	// ray in
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	// result out
	output logic               result_valid,
	output logic               hit,
	output logic signed [31:0] hit_distance,
	output logic signed [31:0] hit_x,
	output logic signed [31:0] hit_y,
	output logic signed [31:0] hit_z,
	output logic [7:0]         hit_material
);

	// configuration registers
	logic signed [31:0] nx_q, ny_q, nz_q, px_q, py_q, pz_q;
	logic [7:0]         mat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q  <= '0;
			ny_q  <= '0;
			nz_q  <= '0;
			px_q  <= '0;
			py_q  <= '0;
			pz_q  <= '0;
			mat_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_NORMAL_X: nx_q  <= wr_data;
				CFG_NORMAL_Y: ny_q  <= wr_data;
				CFG_NORMAL_Z: nz_q  <= wr_data;
				CFG_POINT_X:  px_q  <= wr_data;
				CFG_POINT_Y:  py_q  <= wr_data;
				CFG_POINT_Z:  pz_q  <= wr_data;
				CFG_MATERIAL: mat_q <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	// every cycle can take a ray
	assign busy = 1'b0;

	logic take;
	assign take = start && !busy;

	// stage 1: register the ray and form origin minus plane point (exact, 33 bits)
	logic               vld_s1;
	logic signed [31:0] ox_s1, oy_s1, oz_s1, dx_s1, dy_s1, dz_s1;
	logic signed [32:0] ex_s1, ey_s1, ez_s1;

	// stage 2: the six products
	logic               vld_s2;
	logic signed [31:0] ox_s2, oy_s2, oz_s2, dx_s2, dy_s2, dz_s2;
	logic signed [63:0] pax_s2, pay_s2, paz_s2;
	logic signed [64:0] pbx_s2, pby_s2, pbz_s2;

	// stage 3: floor-shift and sum into a and b
	logic               vld_s3;
	logic signed [31:0] ox_s3, oy_s3, oz_s3, dx_s3, dy_s3, dz_s3;
	logic signed [AW-1:0] a_s3;
	logic signed [BW-1:0] b_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ox_s1 <= origin_x;
		oy_s1 <= origin_y;
		oz_s1 <= origin_z;
		dx_s1 <= dir_x;
		dy_s1 <= dir_y;
		dz_s1 <= dir_z;
		ex_s1 <= 33'(origin_x) - 33'(px_q);
		ey_s1 <= 33'(origin_y) - 33'(py_q);
		ez_s1 <= 33'(origin_z) - 33'(pz_q);

		ox_s2  <= ox_s1;
		oy_s2  <= oy_s1;
		oz_s2  <= oz_s1;
		dx_s2  <= dx_s1;
		dy_s2  <= dy_s1;
		dz_s2  <= dz_s1;
		pax_s2 <= 64'(dx_s1) * 64'(nx_q);
		pay_s2 <= 64'(dy_s1) * 64'(ny_q);
		paz_s2 <= 64'(dz_s1) * 64'(nz_q);
		pbx_s2 <= 65'(nx_q) * 65'(ex_s1);
		pby_s2 <= 65'(ny_q) * 65'(ey_s1);
		pbz_s2 <= 65'(nz_q) * 65'(ez_s1);

		ox_s3 <= ox_s2;
		oy_s3 <= oy_s2;
		oz_s3 <= oz_s2;
		dx_s3 <= dx_s2;
		dy_s3 <= dy_s2;
		dz_s3 <= dz_s2;
		// arithmetic shift is the floor of the scaled product
		a_s3 <= AW'(PW'(pax_s2 >>> FRAC_BITS)) + AW'(PW'(pay_s2 >>> FRAC_BITS))
			+ AW'(PW'(paz_s2 >>> FRAC_BITS));
		b_s3 <= BW'(BPW'(pbx_s2 >>> FRAC_BITS)) + BW'(BPW'(pby_s2 >>> FRAC_BITS))
			+ BW'(BPW'(pbz_s2 >>> FRAC_BITS));
	end

	// divider set-up: magnitudes, sign of the quotient, integer overflow check
	logic [AW-1:0] mag_a;
	logic [BW-1:0] mag_b;
	div_stage_t    dv_init;

	always_comb begin
		mag_a = AW'(-a_s3);
		mag_b = b_s3[BW-1] ? BW'(-b_s3) : BW'(b_s3);
		dv_init        = '0;
		dv_init.hit    = a_s3[AW-1];
		dv_init.neg    = b_s3[BW-1];
		dv_init.mag    = mag_a;
		// integer part of |b|/|a| too large for the 32-bit result
		dv_init.ovf    = CW'(mag_b) >= (CW'(mag_a) << (32 - FRAC_BITS));
		// numerator is |b| scaled by 2^FRAC_BITS; its top bits seed the remainder
		dv_init.rem    = RW'(mag_b >> (32 - FRAC_BITS));
		dv_init.num_lo = QW'(mag_b << FRAC_BITS);
		dv_init.ox     = ox_s3;
		dv_init.oy     = oy_s3;
		dv_init.oz     = oz_s3;
		dv_init.dx     = dx_s3;
		dv_init.dy     = dy_s3;
		dv_init.dz     = dz_s3;
	end

	// restoring divider, one quotient bit per stage
	div_stage_t dv_s [DIV_STAGES+1];
	logic       dv_vld_s [DIV_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else begin
			dv_vld_s[0] <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		dv_s[0] <= dv_init;
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dv_s[k+1] <= div_step(dv_s[k]);
		end
	end

	div_stage_t dv_last;
	assign dv_last = dv_s[DIV_STAGES];

	// distance: apply sign and saturate
	logic signed [31:0] dist_c;

	always_comb begin
		priority if (!dv_last.hit) begin
			dist_c = '0;
		end else if (dv_last.ovf || dv_last.quo[QW-1]) begin
			dist_c = dv_last.neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else if (dv_last.neg) begin
			dist_c = -$signed(dv_last.quo);
		end else begin
			dist_c = $signed(dv_last.quo);
		end
	end

	// distance stage
	logic               vld_s5, hit_s5;
	logic signed [31:0] dist_s5;
	logic signed [31:0] ox_s5, oy_s5, oz_s5, dx_s5, dy_s5, dz_s5;

	// direction times distance
	logic               vld_s6, hit_s6;
	logic signed [31:0] dist_s6;
	logic signed [31:0] ox_s6, oy_s6, oz_s6;
	logic signed [63:0] mx_s6, my_s6, mz_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5       <= 1'b0;
			vld_s6       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			vld_s5       <= dv_vld_s[DIV_STAGES];
			vld_s6       <= vld_s5;
			result_valid <= vld_s6;
		end
	end

	// origin plus the floor-shifted offset, saturated to 32 bits
	function automatic logic signed [31:0] add_sat(input logic signed [31:0] o,
		input logic signed [63:0] m);
		logic signed [PW:0] s;
		s = (PW+1)'(o) + (PW+1)'(PW'(m >>> FRAC_BITS));
		if (s > (PW+1)'(32'sh7fff_ffff)) begin
			return 32'sh7fff_ffff;
		end else if (s < (PW+1)'(32'sh8000_0000)) begin
			return 32'sh8000_0000;
		end else begin
			return 32'(s);
		end
	endfunction

	always_ff @(posedge clk) begin
		hit_s5  <= dv_last.hit;
		dist_s5 <= dist_c;
		ox_s5   <= dv_last.ox;
		oy_s5   <= dv_last.oy;
		oz_s5   <= dv_last.oz;
		dx_s5   <= dv_last.dx;
		dy_s5   <= dv_last.dy;
		dz_s5   <= dv_last.dz;

		hit_s6  <= hit_s5;
		dist_s6 <= dist_s5;
		ox_s6   <= ox_s5;
		oy_s6   <= oy_s5;
		oz_s6   <= oz_s5;
		mx_s6   <= 64'(dx_s5) * 64'(dist_s5);
		my_s6   <= 64'(dy_s5) * 64'(dist_s5);
		mz_s6   <= 64'(dz_s5) * 64'(dist_s5);

		// output register; a miss clears every field
		hit          <= hit_s6;
		hit_distance <= dist_s6;
		hit_x        <= hit_s6 ? add_sat(ox_s6, mx_s6) : 32'sd0;
		hit_y        <= hit_s6 ? add_sat(oy_s6, my_s6) : 32'sd0;
		hit_z        <= hit_s6 ? add_sat(oz_s6, mz_s6) : 32'sd0;
		hit_material <= hit_s6 ? mat_q : 8'd0;
	end

endmodule
